### design/lfmc_pkg.sv
// Package with shared types, register codes and the quarter-wave table function.
`timescale 1ns / 1ps
package lfmc_pkg;

	localparam int CFG_DATA_W      = 48;
	localparam int CFG_INDEX_W     = 2;
	localparam int LEN_W           = 16;
	localparam int MAX_SAMPLE_BITS = 24;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [LEN_W-1:0] LEN_RESET = 16'd1024;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_STEP   = 2'd0,
		REG_STEP_GROWTH  = 2'd1,
		REG_CHIRP_LENGTH = 2'd2
	} lfmc_reg_t;

	typedef struct packed {
		logic sin_neg;
		logic cos_neg;
		logic last;
	} lfmc_flags_t;

	// Entry idx of the quarter-wave sine table, sampled at half-step offsets.
	function automatic logic [MAX_SAMPLE_BITS-2:0] quarter_entry(input int unsigned idx,
			input int unsigned addr_bits, input int unsigned sample_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] prod;
		logic [63:0] sum;
		logic [63:0] ampl;
		logic [63:0] scaled;
		x = (HALF_PI_Q30 * ((64'(idx) << 1) + 64'd1)) >> (addr_bits + 1);
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int k = 1; k <= 7; k++) begin
			prod = (term * x2) >> 30;
			unique case (k)
				1: term = prod / 6;
				2: term = prod / 20;
				3: term = prod / 42;
				4: term = prod / 72;
				5: term = prod / 110;
				6: term = prod / 156;
				default: term = prod / 210;
			endcase
			if ((k % 2) == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		ampl = (64'd1 << (sample_bits - 1)) - 64'd1;
		scaled = (sum * ampl + (64'd1 << 29)) >> 30;
		return scaled[MAX_SAMPLE_BITS-2:0];
	endfunction

endpackage

### design/lfmc_if.sv
// Handshake interfaces for the restart request channel and the sample channel.
`timescale 1ns / 1ps
interface lfmc_restart_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface lfmc_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] cosine_out;
	logic signed [SAMPLE_BITS-1:0] sine_out;
	logic                          last_sample;

	modport source (output valid, output cosine_out, output sine_out, output last_sample,
		input ready);
	modport sink (input valid, input cosine_out, input sine_out, input last_sample,
		output ready);
endinterface

### design/lfmc_rom.sv
// Quarter-wave sine ROM with two synchronous read ports.
`timescale 1ns / 1ps
module lfmc_rom
	import lfmc_pkg::*;
#(
	parameter int TABLE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [TABLE_ADDR_BITS-1:0] sin_addr,
	input  logic [TABLE_ADDR_BITS-1:0] cos_addr,
	output logic [SAMPLE_BITS-2:0]     sin_data,
	output logic [SAMPLE_BITS-2:0]     cos_data
);

	localparam int DEPTH = 1 << TABLE_ADDR_BITS;

	typedef logic [SAMPLE_BITS-2:0] entry_t;
	typedef entry_t rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < DEPTH; i++) begin
			r[i] = entry_t'(quarter_entry(i, TABLE_ADDR_BITS, SAMPLE_BITS));
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sin_data <= ROM[sin_addr];
			cos_data <= ROM[cos_addr];
		end
	end

endmodule

### design/lfmc_phase.sv
// Configuration registers, phase and step accumulators, and table address generation.
`timescale 1ns / 1ps
module lfmc_phase
	import lfmc_pkg::*;
#(
	parameter int TABLE_ADDR_BITS = 10,
	parameter int PHASE_BITS      = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                       fire,
	input  logic                       restart,
	output logic [TABLE_ADDR_BITS-1:0] sin_addr,
	output logic [TABLE_ADDR_BITS-1:0] cos_addr,
	output lfmc_flags_t                flags
);

	logic [CFG_DATA_W-1:0] start_q;
	logic [CFG_DATA_W-1:0] growth_q;
	logic [LEN_W-1:0]      len_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [LEN_W-1:0]      index_q;

	logic [PHASE_BITS-1:0]        eff_phase;
	logic [PHASE_BITS-1:0]        eff_step;
	logic [LEN_W-1:0]             eff_index;
	logic [TABLE_ADDR_BITS+1:0]   wave_idx;
	logic [1:0]                   quad_sin;
	logic [1:0]                   quad_cos;
	logic [TABLE_ADDR_BITS-1:0]   offset;
	logic                         last;
	logic [PHASE_BITS-1:0]        start_ext;
	logic [PHASE_BITS-1:0]        growth_ext;
	logic [PHASE_BITS-1:0]        half_growth;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			growth_q <= '0;
			len_q    <= LEN_RESET;
		end else if (cfg_wr_en) begin
			unique case (lfmc_reg_t'(cfg_index))
				REG_START_STEP:   start_q  <= cfg_wdata;
				REG_STEP_GROWTH:  growth_q <= cfg_wdata;
				REG_CHIRP_LENGTH: len_q    <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_phase   = restart ? '0 : phase_q;
		eff_step    = restart ? '0 : step_q;
		eff_index   = restart ? '0 : index_q;
		wave_idx    = eff_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS+2];
		quad_sin    = wave_idx[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
		quad_cos    = quad_sin + 2'd1;
		offset      = wave_idx[TABLE_ADDR_BITS-1:0];
		sin_addr    = quad_sin[0] ? ~offset : offset;
		cos_addr    = quad_cos[0] ? ~offset : offset;
		last        = (eff_index == (len_q - 16'd1));
		flags       = '{sin_neg: quad_sin[1], cos_neg: quad_cos[1], last: last};
		start_ext   = PHASE_BITS'(start_q);
		growth_ext  = PHASE_BITS'(growth_q);
		half_growth = PHASE_BITS'(growth_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			index_q <= '0;
		end else if (fire) begin
			if (last) begin
				phase_q <= '0;
				step_q  <= '0;
				index_q <= '0;
			end else begin
				phase_q <= eff_phase + start_ext + eff_step + half_growth;
				step_q  <= eff_step + growth_ext;
				index_q <= eff_index + 16'd1;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> phase_q == '0 && step_q == '0 && index_q == '0)
		else $error("Accumulators not cleared after the final sample of a pulse.");

	a_index_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last |=> index_q == $past(eff_index) + 16'd1)
		else $error("Sample index did not advance by one.");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(step_q) && $stable(index_q))
		else $error("Accumulator state changed without a transaction.");

endmodule

### design/lfm_chirp_generator.sv
// Each accepted restart transaction yields a result via the ROM read and output registers.
// Throughput: one sample per clock while the sample channel is not stalled.
// The two-stage output pipeline collapses bubbles, so input is taken whenever a slot frees.
// Reset: arst_n clears the accumulators, the pipeline valid flags and the registers
// (start_step and step_growth to zero, chirp_length to 1024); the ROM needs no clearing.
`timescale 1ns / 1ps
module lfm_chirp_generator
	import lfmc_pkg::*;
#(
	parameter int TABLE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS     = 16,
	parameter int PHASE_BITS      = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	lfmc_restart_if.sink           restart_ch,
	lfmc_sample_if.source          sample_ch
);

	logic                       adv_s1;
	logic                       adv_s2;
	logic                       fire;
	logic [TABLE_ADDR_BITS-1:0] sin_addr;
	logic [TABLE_ADDR_BITS-1:0] cos_addr;
	lfmc_flags_t                flags;
	logic [SAMPLE_BITS-2:0]     sin_data_s1;
	logic [SAMPLE_BITS-2:0]     cos_data_s1;
	lfmc_flags_t                flags_s1;
	logic                       valid_s1;
	logic                       valid_s2;
	logic [SAMPLE_BITS-1:0]     sin_mag;
	logic [SAMPLE_BITS-1:0]     cos_mag;
	logic signed [SAMPLE_BITS-1:0] sine_s2;
	logic signed [SAMPLE_BITS-1:0] cosine_s2;
	logic                       last_s2;

	assign adv_s2           = !valid_s2 || sample_ch.ready;
	assign adv_s1           = !valid_s1 || adv_s2;
	assign restart_ch.ready = adv_s1;
	assign fire             = restart_ch.valid && adv_s1;

	lfmc_phase #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS),
		.PHASE_BITS     (PHASE_BITS)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fire     (fire),
		.restart  (restart_ch.restart),
		.sin_addr (sin_addr),
		.cos_addr (cos_addr),
		.flags    (flags)
	);

	lfmc_rom #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_rom (
		.clk     (clk),
		.rd_en   (adv_s1),
		.sin_addr(sin_addr),
		.cos_addr(cos_addr),
		.sin_data(sin_data_s1),
		.cos_data(cos_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= fire;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			flags_s1 <= flags;
		end
	end

	always_comb begin
		sin_mag = {1'b0, sin_data_s1};
		cos_mag = {1'b0, cos_data_s1};
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			sine_s2   <= flags_s1.sin_neg ? -sin_mag : sin_mag;
			cosine_s2 <= flags_s1.cos_neg ? -cos_mag : cos_mag;
			last_s2   <= flags_s1.last;
		end
	end

	assign sample_ch.valid       = valid_s2;
	assign sample_ch.sine_out    = sine_s2;
	assign sample_ch.cosine_out  = cosine_s2;
	assign sample_ch.last_sample = last_s2;

	a_s2_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("Output became valid without a sample in the first stage.");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(sin_data_s1) && $stable(cos_data_s1))
		else $error("First stage lost its sample while the output stalled.");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !sample_ch.ready |=> valid_s2 && $stable(sine_s2) && $stable(cosine_s2)
			&& $stable(last_s2))
		else $error("Output transaction changed while it waited.");

endmodule

### sim/lfm_chirp_generator_tb.sv
// Self-checking testbench for the linear FM chirp generator with its own phase and table model.
`timescale 1ns / 1ps
module lfm_chirp_generator_tb;
	import lfmc_pkg::*;

	localparam logic [47:0] STEP_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic signed [15:0] cosine;
		logic signed [15:0] sine;
		logic               last_flag;
	} chirp_sample_t;

	logic clk;
	logic arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	lfmc_restart_if restart_ch ();
	lfmc_sample_if #(.SAMPLE_BITS(16)) sample_ch ();

	lfm_chirp_generator #(
		.TABLE_ADDR_BITS(10),
		.SAMPLE_BITS(16),
		.PHASE_BITS(48)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.restart_ch(restart_ch),
		.sample_ch(sample_ch)
	);

	logic [14:0] sine_rom [0:1023];
	logic [47:0] reg_start_step;
	logic [47:0] reg_step_growth;
	logic [15:0] reg_chirp_length;
	logic [47:0] nco_phase;
	logic [47:0] nco_step;
	logic [15:0] pulse_index;

	bit            restart_pending[$];
	chirp_sample_t sample_expect[$];
	int            failures = 0;

	function automatic logic [14:0] rom_entry(input int unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned total;
		longint unsigned divisor;
		x = (HALF_PI_Q30 * (64'd2 * i + 64'd1)) >> 11;
		x2 = (x * x) >> 30;
		term = x;
		total = x;
		for (int k = 1; k <= 7; k++) begin
			divisor = 64'(2 * k) * 64'(2 * k + 1);
			term = ((term * x2) >> 30) / divisor;
			if (k % 2 == 1) begin
				total = (total >= term) ? total - term : 64'd0;
			end else begin
				total = total + term;
			end
		end
		if (total > ONE_Q30) begin
			total = ONE_Q30;
		end
		return 15'((total * 64'd32767 + (64'd1 << 29)) >> 30);
	endfunction

	function automatic logic [15:0] quarter_wave(input logic [11:0] j);
		logic [9:0]  m;
		logic [15:0] v;
		m = j[9:0];
		if (j[10]) begin
			m = 10'd1023 - m;
		end
		v = {1'b0, sine_rom[m]};
		if (j[11]) begin
			v = -v;
		end
		return v;
	endfunction

	function automatic chirp_sample_t chirp_predict(input logic restart);
		chirp_sample_t s;
		logic [11:0]   j;
		if (restart) begin
			nco_phase = '0;
			nco_step = '0;
			pulse_index = '0;
		end
		j = nco_phase[47:36];
		s.cosine = quarter_wave(j + 12'd1024);
		s.sine = quarter_wave(j);
		s.last_flag = (pulse_index == reg_chirp_length - 16'd1);
		if (s.last_flag) begin
			nco_phase = '0;
			nco_step = '0;
			pulse_index = '0;
		end else begin
			nco_phase = nco_phase + reg_start_step + nco_step + (reg_step_growth >> 1);
			nco_step = nco_step + reg_step_growth;
			pulse_index = pulse_index + 16'd1;
		end
		return s;
	endfunction

	function automatic logic [47:0] pick_step();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return STEP_MAX;
			2: return 48'({$urandom(), $urandom()});
			3: return 48'($urandom_range(0, 1023));
			4: return 48'd1 << $urandom_range(0, 47);
			default: return 48'({$urandom_range(0, 15), $urandom()});
		endcase
	endfunction

	function automatic logic [15:0] pick_length();
		case ($urandom_range(0, 7))
			0: return 16'd1;
			1, 2: return 16'($urandom_range(2, 16));
			3, 4: return 16'($urandom_range(17, 300));
			5: return 16'hFFFF;
			6: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic write_reg(input lfmc_reg_t idx, input logic [47:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_START_STEP: reg_start_step = data;
			REG_STEP_GROWTH: reg_step_growth = data;
			REG_CHIRP_LENGTH: reg_chirp_length = data[15:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (restart_pending.size() != 0 || restart_ch.valid || sample_expect.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : restart_driver
		int burst_left;
		int gap_left;
		bit offer;
		bit next_restart;
		if (!arst_n) begin
			restart_ch.valid <= 1'b0;
			restart_ch.restart <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			nco_phase = '0;
			nco_step = '0;
			pulse_index = '0;
		end else begin
			if (restart_ch.valid && restart_ch.ready) begin
				sample_expect.push_back(chirp_predict(restart_ch.restart));
			end
			if (!restart_ch.valid || restart_ch.ready) begin
				offer = 1'b0;
				next_restart = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (restart_pending.size() > 0) begin
					offer = 1'b1;
					next_restart = restart_pending.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
							: $urandom_range(0, 12);
						gap_left = $urandom_range(0, 6);
					end
				end
				restart_ch.valid <= offer;
				restart_ch.restart <= offer ? next_restart : 1'($urandom_range(0, 1));
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : sample_monitor
		int hold_left;
		int results_seen;
		int stall_mode;
		int stall_cnt;
		bit hold_done;
		bit next_ready;
		chirp_sample_t exp_s;
		if (!arst_n) begin
			sample_ch.ready <= 1'b0;
			hold_left = 0;
			results_seen = 0;
			stall_mode = 0;
			stall_cnt = 0;
			hold_done = 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				results_seen++;
				if (sample_expect.size() == 0) begin
					$error("sample transaction with no expected sample");
					failures++;
				end else begin
					exp_s = sample_expect.pop_front();
					if (sample_ch.cosine_out !== exp_s.cosine) begin
						$error("cosine_out: expected %0d, actual %0d", exp_s.cosine,
							sample_ch.cosine_out);
						failures++;
					end
					if (sample_ch.sine_out !== exp_s.sine) begin
						$error("sine_out: expected %0d, actual %0d", exp_s.sine,
							sample_ch.sine_out);
						failures++;
					end
					if (sample_ch.last_sample !== exp_s.last_flag) begin
						$error("last_sample: expected %0d, actual %0d", exp_s.last_flag,
							sample_ch.last_sample);
						failures++;
					end
				end
			end
			stall_cnt++;
			if (stall_cnt % 128 == 0) begin
				stall_mode = $urandom_range(0, 3);
			end
			if (!hold_done && results_seen >= 400 && restart_ch.valid) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else begin
				case (stall_mode)
					0: next_ready = 1'b1;
					1: next_ready = 1'($urandom_range(0, 1));
					2: next_ready = ($urandom_range(0, 3) != 0);
					default: next_ready = stall_cnt[3];
				endcase
			end
			sample_ch.ready <= next_ready;
		end
	end

	initial begin : stimulus
		int random_total;
		int phase_items;
		int restart_odds;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_START_STEP;
		cfg_wdata <= '0;
		for (int i = 0; i < 1024; i++) begin
			sine_rom[i] = rom_entry(i);
		end
		reg_start_step = '0;
		reg_step_growth = '0;
		reg_chirp_length = LEN_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Register values after reset.
		@(negedge clk);
		restart_pending = '{1, 0, 0, 0};
		wait_drained();

		// Largest steps with an odd growth, one sample per pulse.
		write_reg(REG_START_STEP, STEP_MAX);
		write_reg(REG_STEP_GROWTH, STEP_MAX);
		write_reg(REG_CHIRP_LENGTH, {32'hFFFF_FFFF, 16'd1});
		@(negedge clk);
		restart_pending = '{0, 1, 0, 1, 0, 0};
		wait_drained();

		// Odd growth of one drops its half step; restart in the middle of a pulse.
		write_reg(REG_START_STEP, 48'd0);
		write_reg(REG_STEP_GROWTH, 48'd1);
		write_reg(REG_CHIRP_LENGTH, 48'd3);
		@(negedge clk);
		restart_pending = '{1, 0, 0, 0, 0, 1, 0};
		wait_drained();

		// Quarter-turn steps with a zero length, which gives the longest pulse.
		write_reg(REG_START_STEP, 48'd1 << 46);
		write_reg(REG_STEP_GROWTH, 48'd0);
		write_reg(REG_CHIRP_LENGTH, 48'd0);
		@(negedge clk);
		restart_pending = '{1, 0, 0, 0, 0};
		wait_drained();

		// Length lowered below the running index, then a new pulse.
		write_reg(REG_CHIRP_LENGTH, 48'd2);
		@(negedge clk);
		restart_pending = '{0, 0, 1, 0, 0, 0};
		wait_drained();

		random_total = 0;
		while (random_total < 1700) begin
			if ($urandom_range(0, 2) != 0) begin
				write_reg(REG_START_STEP, pick_step());
			end
			if ($urandom_range(0, 2) != 0) begin
				write_reg(REG_STEP_GROWTH, pick_step());
			end
			if ($urandom_range(0, 2) != 0) begin
				write_reg(REG_CHIRP_LENGTH, {32'($urandom()), pick_length()});
			end
			case ($urandom_range(0, 5))
				0: restart_odds = 2;
				1, 2: restart_odds = 16;
				default: restart_odds = 64;
			endcase
			phase_items = $urandom_range(40, 250);
			@(negedge clk);
			restart_pending.push_back(1'b1);
			for (int i = 1; i < phase_items; i++) begin
				restart_pending.push_back($urandom_range(1, restart_odds) == 1);
			end
			random_total += phase_items;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
